>>> sv/drc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_pkg
// shared types, widths and codes for the distance range constraint pipeline
// ----------------------------------------------------------------------------
package drc_pkg;

   localparam int COORD_W   = 32;  // signed q23.8 coordinate
   localparam int LEN_W     = 31;  // unsigned q23.8 length register
   localparam int MASS_W    = 24;  // unsigned q16.8 mass
   localparam int DIFF_W    = 33;  // signed anchor difference
   localparam int MAG_W     = 33;  // magnitude of a difference or of the overshoot
   localparam int RAD_W     = 66;  // sum of squares
   localparam int ROOT_W    = 33;  // integer root of the sum of squares
   localparam int REM_W     = 34;  // root remainder
   localparam int DEN_W     = 25;  // mass sum
   localparam int PROD_W    = 57;  // overshoot times weight numerator
   localparam int DIV_W     = 58;  // gap times weight denominator
   localparam int NUM_W     = 90;  // dividend
   localparam int QUO_W     = 33;  // quotient, bounded by the overshoot
   localparam int LANES     = 4;
   localparam int SQ_STAGES = ROOT_W;
   localparam int DV_STAGES = QUO_W;

   localparam int LANE_FIRST_X  = 0;
   localparam int LANE_FIRST_Y  = 1;
   localparam int LANE_SECOND_X = 2;
   localparam int LANE_SECOND_Y = 3;

   // configuration port
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_MIN_LENGTH = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_MAX_LENGTH = 1'b1;
   localparam logic [LEN_W-1:0]     MAX_LENGTH_RESET = '1;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_point_x;
      logic signed [COORD_W-1:0] first_point_y;
      logic signed [COORD_W-1:0] second_point_x;
      logic signed [COORD_W-1:0] second_point_y;
      logic signed [COORD_W-1:0] first_center_x;
      logic signed [COORD_W-1:0] first_center_y;
      logic signed [COORD_W-1:0] second_center_x;
      logic signed [COORD_W-1:0] second_center_y;
      logic        [MASS_W-1:0]  first_mass;
      logic        [MASS_W-1:0]  second_mass;
      logic                      first_fixed;
      logic                      second_fixed;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] new_first_x;
      logic signed [COORD_W-1:0] new_first_y;
      logic signed [COORD_W-1:0] new_second_x;
      logic signed [COORD_W-1:0] new_second_y;
   } rsp_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0] c1x;
      logic [COORD_W-1:0] c1y;
      logic [COORD_W-1:0] c2x;
      logic [COORD_W-1:0] c2y;
   } ctr_type;

   typedef struct packed {
      logic [MASS_W-1:0] n1;
      logic [MASS_W-1:0] n2;
      logic [DEN_W-1:0]  den;
   } wt_type;

   // side data that rides along the root pipeline
   typedef struct packed {
      logic             dx_neg;
      logic             dy_neg;
      logic [MAG_W-1:0] dx_mag;
      logic [MAG_W-1:0] dy_mag;
      wt_type           wt;
      ctr_type          ctr;
   } sq_tag_type;

   // side data that rides along the divider pipeline
   typedef struct packed {
      logic    dx_neg;
      logic    dy_neg;
      logic    delta_neg;
      logic    mv_en;
      ctr_type ctr;
   } dv_tag_type;

endpackage

>>> sv/drc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_req_if
// input item channel: valid, ready and the item payload
// ----------------------------------------------------------------------------
interface drc_req_if import drc_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/drc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_rsp_if
// result item channel: valid, ready and the result payload
// ----------------------------------------------------------------------------
interface drc_rsp_if import drc_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/drc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module drc_sqrt import drc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  sq_tag_type        in_tag,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output sq_tag_type        out_tag
);

   logic              vld_ff  [SQ_STAGES];
   logic [RAD_W-1:0]  rad_ff  [SQ_STAGES];
   logic [REM_W-1:0]  rem_ff  [SQ_STAGES];
   logic [ROOT_W-1:0] root_ff [SQ_STAGES];
   sq_tag_type        tag_ff  [SQ_STAGES];

   for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
      logic              prev_vld;
      logic [RAD_W-1:0]  prev_rad;
      logic [REM_W-1:0]  prev_rem;
      logic [ROOT_W-1:0] prev_root;
      sq_tag_type        prev_tag;
      logic [REM_W+1:0]  trial_val;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  diff;
      logic              ge;
      logic [REM_W-1:0]  rem_in;

      if (s == 0) begin : g_head
         assign prev_vld  = in_valid;
         assign prev_rad  = in_rad;
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_tag  = in_tag;
      end else begin : g_body
         assign prev_vld  = vld_ff[s-1];
         assign prev_rad  = rad_ff[s-1];
         assign prev_rem  = rem_ff[s-1];
         assign prev_root = root_ff[s-1];
         assign prev_tag  = tag_ff[s-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign trial_val = {prev_rem, prev_rad[RAD_W-1:RAD_W-2]};
      assign trial     = {1'b0, prev_root, 2'b01};
      assign ge        = trial_val >= trial;
      assign diff      = trial_val - trial;
      assign rem_in    = ge ? diff[REM_W-1:0] : trial_val[REM_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= {prev_rad[RAD_W-3:0], 2'b00};
            rem_ff[s]  <= rem_in;
            root_ff[s] <= {prev_root[ROOT_W-2:0], ge};
            tag_ff[s]  <= prev_tag;
         end
      end
   end

   assign out_valid = vld_ff[SQ_STAGES-1];
   assign out_root  = root_ff[SQ_STAGES-1];
   assign out_tag   = tag_ff[SQ_STAGES-1];

   // the remainder of a floor root never exceeds twice the root
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQ_STAGES-1] |-> rem_ff[SQ_STAGES-1] <= {root_ff[SQ_STAGES-1], 1'b0})
      else $error("root remainder out of range");

endmodule

>>> sv/drc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_div
// pipelined restoring divider, four lanes sharing one divisor, one bit a stage
// ----------------------------------------------------------------------------
module drc_div import drc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num [LANES],
   input  logic [DIV_W-1:0] in_den,
   input  dv_tag_type       in_tag,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo [LANES],
   output dv_tag_type       out_tag
);

   logic             vld_ff [DV_STAGES];
   logic [DIV_W-1:0] den_ff [DV_STAGES];
   dv_tag_type       tag_ff [DV_STAGES];
   logic [DIV_W-1:0] rem_ff [DV_STAGES][LANES];
   logic [QUO_W-1:0] qn_ff  [DV_STAGES][LANES];

   for (genvar s = 0; s < DV_STAGES; s++) begin : g_stage
      logic             prev_vld;
      logic [DIV_W-1:0] prev_den;
      dv_tag_type       prev_tag;

      if (s == 0) begin : g_head
         assign prev_vld = in_valid;
         assign prev_den = in_den;
         assign prev_tag = in_tag;
      end else begin : g_body
         assign prev_vld = vld_ff[s-1];
         assign prev_den = den_ff[s-1];
         assign prev_tag = tag_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[s] <= prev_den;
            tag_ff[s] <= prev_tag;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DIV_W-1:0] prev_rem;
         logic [QUO_W-1:0] prev_qn;
         logic [DIV_W:0]   shifted;
         logic [DIV_W:0]   diff;
         logic             ge;
         logic [DIV_W-1:0] rem_in;

         if (s == 0) begin : g_head
            // the quotient fits QUO_W bits, so the top part is below the divisor
            assign prev_rem = {1'b0, in_num[l][NUM_W-1:QUO_W]};
            assign prev_qn  = in_num[l][QUO_W-1:0];
         end else begin : g_body
            assign prev_rem = rem_ff[s-1][l];
            assign prev_qn  = qn_ff[s-1][l];
         end

         assign shifted = {prev_rem, prev_qn[QUO_W-1]};
         assign ge      = shifted >= {1'b0, prev_den};
         assign diff    = shifted - {1'b0, prev_den};
         assign rem_in  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s][l] <= rem_in;
               qn_ff[s][l]  <= {prev_qn[QUO_W-2:0], ge};
            end
         end
      end
   end

   assign out_valid = vld_ff[DV_STAGES-1];
   assign out_tag   = tag_ff[DV_STAGES-1];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = qn_ff[DV_STAGES-1][l];
      end
   end

   // with a real move the final remainders stay below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DV_STAGES-1] && tag_ff[DV_STAGES-1].mv_en |->
         rem_ff[DV_STAGES-1][LANE_FIRST_X]  < den_ff[DV_STAGES-1] &&
         rem_ff[DV_STAGES-1][LANE_FIRST_Y]  < den_ff[DV_STAGES-1] &&
         rem_ff[DV_STAGES-1][LANE_SECOND_X] < den_ff[DV_STAGES-1] &&
         rem_ff[DV_STAGES-1][LANE_SECOND_Y] < den_ff[DV_STAGES-1])
      else $error("divider remainder not below divisor");

endmodule

>>> sv/distance_range_constraint.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_range_constraint
// keeps the gap between two anchors inside [min_length, max_length] by moving
// the two centers along the anchor direction, shared by inverse mass
// ----------------------------------------------------------------------------
// One item enters per clock while the output register is free or being read,
// and passes through the registers that form the anchor difference, its
// magnitude, the squares and their sum, the square root (one root bit per
// stage), the registers for the overshoot, the weight products, the split
// dividend multiplies and their sum, the four-lane divider (one quotient bit
// per stage) and the saturating add into the output register. All stages
// advance together whenever the output register is empty or being read, so a
// stalled result holds the whole pipeline and the input sees ready low until
// it drains one slot. min_length and max_length are read at byte offsets 0 and 4.
// Write them only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module distance_range_constraint import drc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   drc_req_if.sink            req_ch,
   drc_rsp_if.source          rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   localparam int PART_W = 29;                 // low slice of the weighted overshoot
   localparam int LO_W   = MAG_W + PART_W;
   localparam int HI_W   = MAG_W + PROD_W - PART_W;
   localparam int SUM_W  = QUO_W + 3;          // center plus signed move, no wrap

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sh8000_0000);

   // ---------------------------------------------------------------- registers
   logic [LEN_W-1:0]         min_length_ff;
   logic [LEN_W-1:0]         max_length_ff;
   logic                     csr_wr;
   logic [REG_IDX_W-1:0]     csr_idx;

   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[PADDR_W-1:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= '0;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MIN_LENGTH: min_length_ff <= pwdata[LEN_W-1:0];
            REG_MAX_LENGTH: max_length_ff <= pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MIN_LENGTH: prdata = {1'b0, min_length_ff};
         REG_MAX_LENGTH: prdata = {1'b0, max_length_ff};
         default:        prdata = '0;
      endcase
   end

   // ----------------------------------------------------------- flow control
   // everything moves when the output slot is free or is being taken
   logic            en;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   assign en            = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = en;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.data   = rsp_data_ff;

   // ------------------------------------------- stage 1: differences, weights
   logic                     s1_vld_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff;
   wt_type                   s1_wt_ff;
   ctr_type                  s1_ctr_ff;
   logic signed [DIFF_W-1:0] s1_dx_in, s1_dy_in;
   wt_type                   s1_wt_in;
   logic [DEN_W-1:0]         mass_sum;

   assign s1_dx_in = {req_ch.data.second_point_x[COORD_W-1], req_ch.data.second_point_x}
                   - {req_ch.data.first_point_x[COORD_W-1], req_ch.data.first_point_x};
   assign s1_dy_in = {req_ch.data.second_point_y[COORD_W-1], req_ch.data.second_point_y}
                   - {req_ch.data.first_point_y[COORD_W-1], req_ch.data.first_point_y};
   assign mass_sum = {1'b0, req_ch.data.first_mass} + {1'b0, req_ch.data.second_mass};

   // inverse mass share; one fixed item, or a zero mass sum, sends it all one way, and two fixed items get no move
   always_comb begin
      s1_wt_in.n1  = '0;
      s1_wt_in.n2  = '0;
      s1_wt_in.den = DEN_W'(1);
      if (!req_ch.data.first_fixed) begin
         if (!req_ch.data.second_fixed && mass_sum != '0) begin
            s1_wt_in.n1  = req_ch.data.second_mass;
            s1_wt_in.n2  = req_ch.data.first_mass;
            s1_wt_in.den = mass_sum;
         end else begin
            s1_wt_in.n1 = MASS_W'(1);
         end
      end else if (!req_ch.data.second_fixed) begin
         s1_wt_in.n2 = MASS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff      <= s1_dx_in;
         s1_dy_ff      <= s1_dy_in;
         s1_wt_ff      <= s1_wt_in;
         s1_ctr_ff.c1x <= req_ch.data.first_center_x;
         s1_ctr_ff.c1y <= req_ch.data.first_center_y;
         s1_ctr_ff.c2x <= req_ch.data.second_center_x;
         s1_ctr_ff.c2y <= req_ch.data.second_center_y;
      end
   end

   // --------------------------------------------------- stage 2: magnitudes
   logic       s2_vld_ff;
   sq_tag_type s2_tag_ff;
   sq_tag_type s2_tag_in;

   always_comb begin
      s2_tag_in.dx_neg = s1_dx_ff[DIFF_W-1];
      s2_tag_in.dy_neg = s1_dy_ff[DIFF_W-1];
      s2_tag_in.dx_mag = s1_dx_ff[DIFF_W-1] ? MAG_W'(-s1_dx_ff) : MAG_W'(s1_dx_ff);
      s2_tag_in.dy_mag = s1_dy_ff[DIFF_W-1] ? MAG_W'(-s1_dy_ff) : MAG_W'(s1_dy_ff);
      s2_tag_in.wt     = s1_wt_ff;
      s2_tag_in.ctr    = s1_ctr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_tag_ff <= s2_tag_in;
      end
   end

   // ------------------------------------------------------ stage 3: squares
   logic             s3_vld_ff;
   logic [RAD_W-1:0] s3_sqx_ff, s3_sqy_ff;
   sq_tag_type       s3_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_sqx_ff <= RAD_W'(s2_tag_ff.dx_mag) * RAD_W'(s2_tag_ff.dx_mag);
         s3_sqy_ff <= RAD_W'(s2_tag_ff.dy_mag) * RAD_W'(s2_tag_ff.dy_mag);
         s3_tag_ff <= s2_tag_ff;
      end
   end

   // -------------------------------------------------- stage 4: sum of squares
   logic             s4_vld_ff;
   logic [RAD_W-1:0] s4_rad_ff;
   sq_tag_type       s4_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_rad_ff <= s3_sqx_ff + s3_sqy_ff;
         s4_tag_ff <= s3_tag_ff;
      end
   end

   // ---------------------------------------------------------- gap, floor root
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   sq_tag_type        sq_tag;

   drc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_vld_ff),
      .in_rad    (s4_rad_ff),
      .in_tag    (s4_tag_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // ----------------------------------------------------- stage 5: overshoot
   logic              s5_vld_ff;
   logic [ROOT_W-1:0] s5_d_ff;
   logic [MAG_W-1:0]  s5_dmag_ff, s5_xmag_ff, s5_ymag_ff;
   wt_type            s5_wt_ff;
   dv_tag_type        s5_tag_ff;
   logic              d_gt, d_lt;
   logic [MAG_W-1:0]  s5_dmag_in;
   dv_tag_type        s5_tag_in;

   // the max_length test wins when the window is inverted
   assign d_gt = sq_root > {2'b00, max_length_ff};
   assign d_lt = sq_root < {2'b00, min_length_ff};
   assign s5_dmag_in = d_gt ? sq_root - {2'b00, max_length_ff}
                            : {2'b00, min_length_ff} - sq_root;

   always_comb begin
      s5_tag_in.dx_neg    = sq_tag.dx_neg;
      s5_tag_in.dy_neg    = sq_tag.dy_neg;
      s5_tag_in.delta_neg = !d_gt;
      s5_tag_in.mv_en     = (sq_root != '0) && (d_gt || d_lt);
      s5_tag_in.ctr       = sq_tag.ctr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_d_ff    <= sq_root;
         s5_dmag_ff <= s5_dmag_in;
         s5_xmag_ff <= sq_tag.dx_mag;
         s5_ymag_ff <= sq_tag.dy_mag;
         s5_wt_ff   <= sq_tag.wt;
         s5_tag_ff  <= s5_tag_in;
      end
   end

   // -------------------------------------- stage 6: weighted overshoot, divisor
   logic              s6_vld_ff;
   logic [PROD_W-1:0] s6_pf_ff, s6_ps_ff;
   logic [DIV_W-1:0]  s6_den_ff;
   logic [MAG_W-1:0]  s6_xmag_ff, s6_ymag_ff;
   dv_tag_type        s6_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_pf_ff   <= PROD_W'(s5_dmag_ff) * PROD_W'(s5_wt_ff.n1);
         s6_ps_ff   <= PROD_W'(s5_dmag_ff) * PROD_W'(s5_wt_ff.n2);
         s6_den_ff  <= DIV_W'(s5_d_ff) * DIV_W'(s5_wt_ff.den);
         s6_xmag_ff <= s5_xmag_ff;
         s6_ymag_ff <= s5_ymag_ff;
         s6_tag_ff  <= s5_tag_ff;
      end
   end

   // ----------------------------------- stage 7: dividend partial products
   logic              s7_vld_ff;
   logic [LO_W-1:0]   s7_lo_ff [LANES];
   logic [HI_W-1:0]   s7_hi_ff [LANES];
   logic [DIV_W-1:0]  s7_den_ff;
   dv_tag_type        s7_tag_ff;
   logic [MAG_W-1:0]  lane_mag [LANES];
   logic [PROD_W-1:0] lane_p   [LANES];
   logic [LO_W-1:0]   s7_lo_in [LANES];
   logic [HI_W-1:0]   s7_hi_in [LANES];

   assign lane_mag[LANE_FIRST_X]  = s6_xmag_ff;
   assign lane_mag[LANE_FIRST_Y]  = s6_ymag_ff;
   assign lane_mag[LANE_SECOND_X] = s6_xmag_ff;
   assign lane_mag[LANE_SECOND_Y] = s6_ymag_ff;
   assign lane_p[LANE_FIRST_X]    = s6_pf_ff;
   assign lane_p[LANE_FIRST_Y]    = s6_pf_ff;
   assign lane_p[LANE_SECOND_X]   = s6_ps_ff;
   assign lane_p[LANE_SECOND_Y]   = s6_ps_ff;

   // the weighted overshoot is split so each multiply stays near 33 by 29
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s7_lo_in[l] = LO_W'(lane_mag[l]) * LO_W'(lane_p[l][PART_W-1:0]);
         s7_hi_in[l] = HI_W'(lane_mag[l]) * HI_W'(lane_p[l][PROD_W-1:PART_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_lo_ff  <= s7_lo_in;
         s7_hi_ff  <= s7_hi_in;
         s7_den_ff <= s6_den_ff;
         s7_tag_ff <= s6_tag_ff;
      end
   end

   // ------------------------------------------------ stage 8: full dividends
   logic             s8_vld_ff;
   logic [NUM_W-1:0] s8_num_ff [LANES];
   logic [DIV_W-1:0] s8_den_ff;
   dv_tag_type       s8_tag_ff;
   logic [NUM_W-1:0] s8_num_in [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s8_num_in[l] = NUM_W'(s7_lo_ff[l]) + (NUM_W'(s7_hi_ff[l]) << PART_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (en) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_num_ff <= s8_num_in;
         s8_den_ff <= s7_den_ff;
         s8_tag_ff <= s7_tag_ff;
      end
   end

   // ------------------------------------------------------ move magnitudes
   logic             dv_vld;
   logic [QUO_W-1:0] dv_quo [LANES];
   dv_tag_type       dv_tag;

   drc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_vld_ff),
      .in_num    (s8_num_ff),
      .in_den    (s8_den_ff),
      .in_tag    (s8_tag_ff),
      .out_valid (dv_vld),
      .out_quo   (dv_quo),
      .out_tag   (dv_tag)
   );

   // ------------------------------------ output stage: signed move, saturate
   function automatic logic [COORD_W-1:0] sat_move(input logic [COORD_W-1:0] center,
                                                   input logic [QUO_W-1:0]   mag,
                                                   input logic               neg);
      logic signed [SUM_W-1:0] mv;
      logic signed [SUM_W-1:0] total;
      mv = SUM_W'(mag);
      if (neg) begin
         mv = -mv;
      end
      total = {{(SUM_W-COORD_W){center[COORD_W-1]}}, center} + mv;
      if (total > SAT_HI) begin
         total = SAT_HI;
      end else if (total < SAT_LO) begin
         total = SAT_LO;
      end
      return total[COORD_W-1:0];
   endfunction

   logic [QUO_W-1:0] mv_mag [LANES];
   logic             neg_fx, neg_fy;
   rsp_payload_type  rsp_data_in;

   // first item moves with sign(c) * sign(delta), the second against it
   assign neg_fx = dv_tag.dx_neg ^ dv_tag.delta_neg;
   assign neg_fy = dv_tag.dy_neg ^ dv_tag.delta_neg;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mv_mag[l] = dv_tag.mv_en ? dv_quo[l] : '0;
      end
      rsp_data_in.new_first_x  = sat_move(dv_tag.ctr.c1x, mv_mag[LANE_FIRST_X],  neg_fx);
      rsp_data_in.new_first_y  = sat_move(dv_tag.ctr.c1y, mv_mag[LANE_FIRST_Y],  neg_fy);
      rsp_data_in.new_second_x = sat_move(dv_tag.ctr.c2x, mv_mag[LANE_SECOND_X], !neg_fx);
      rsp_data_in.new_second_y = sat_move(dv_tag.ctr.c2y, mv_mag[LANE_SECOND_Y], !neg_fy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // an item inside the length window, or with zero gap, keeps its centers
   a_no_move_keeps_centers: assert property (@(posedge clock) disable iff (reset)
      en && dv_vld && !dv_tag.mv_en |=>
         rsp_data_ff.new_first_x == $past(dv_tag.ctr.c1x) &&
         rsp_data_ff.new_first_y == $past(dv_tag.ctr.c1y) &&
         rsp_data_ff.new_second_x == $past(dv_tag.ctr.c2x) &&
         rsp_data_ff.new_second_y == $past(dv_tag.ctr.c2y))
      else $error("centers changed without a move");

endmodule
